>>> rtl/osaed_pkg.sv
// shared types, codes and helpers for the edit distance row engine
`default_nettype none

package osaed_pkg;

  localparam int DIST_W = 6;
  localparam logic [DIST_W-1:0] DIST_MAX = 6'd63;

  // item kind carried in tuser
  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_PUSH  = 2'd1,
    MODE_TRUNC = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // configuration register indexes
  localparam logic [0:0] CFG_QUERY_LENGTH = 1'b0;
  localparam logic [0:0] CFG_MAX_DISTANCE = 1'b1;

  typedef struct packed {
    logic capture;
    logic exec;
    logic rep_init;
    logic walk;
    logic emit;
  } osaed_cmd_t;

  typedef struct packed {
    logic push_ok;
    logic walk_done;
    logic out_free;
  } osaed_stat_t;

  function automatic logic [DIST_W-1:0] dsat(input logic [7:0] x);
    return (x > 8'(DIST_MAX)) ? DIST_MAX : x[DIST_W-1:0];
  endfunction

  function automatic logic [DIST_W:0] min7(input logic [DIST_W:0] a,
                                           input logic [DIST_W:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

`default_nettype wire

>>> rtl/osaed_ctrl.sv
// controller state machine sequencing decode, column walk and result hand-off
`default_nettype none

module osaed_ctrl
  import osaed_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire osaed_stat_t stat,
  output osaed_cmd_t       cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECODE = 5'b00010,
    ST_RINIT  = 5'b00100,
    ST_WALK   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
        if (in_tvalid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        cmd.exec  = 1'b1;
        // a push that finds room builds its row and gets min and last on the way
        state_nxt = stat.push_ok ? ST_WALK : ST_RINIT;
      end
      ST_RINIT: begin
        cmd.rep_init = 1'b1;
        state_nxt    = ST_WALK;
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.emit = stat.out_free;
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/osaed_datapath.sv
// datapath: config registers, query/candidate/row memories, column cell and result register
`default_nettype none

module osaed_datapath
  import osaed_pkg::*;
#(
  parameter int MAX_QUERY = 32,
  parameter int MAX_ROWS  = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wen,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [5:0]  cfg_wdata,
  input  wire logic [23:0] in_tdata,
  input  wire logic [7:0]  in_tuser,
  input  wire osaed_cmd_t  cmd,
  output osaed_stat_t      stat,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata
);

  localparam int QA_W   = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
  localparam int CA_W   = $clog2(MAX_ROWS);
  localparam int RC_W   = $clog2(MAX_ROWS + 1);
  localparam int COL_W  = $clog2(MAX_QUERY + 2);
  localparam int RDEPTH = MAX_ROWS * MAX_QUERY;
  localparam int AW     = $clog2(RDEPTH);
  localparam int PW     = $clog2(RDEPTH + 1);

  // memories
  logic [7:0]        qmem    [MAX_QUERY];
  logic [7:0]        cmem    [MAX_ROWS];
  logic [DIST_W-1:0] row_mem [RDEPTH];

  // captured word
  logic [1:0] mode_r;
  logic [7:0] ch_r;
  logic [4:0] qi_r;
  logic [5:0] keep_r;

  logic [5:0]      qlen_r, maxd_r;
  logic [RC_W-1:0] rc_r;
  logic            full_r;
  logic            build_r;

  logic [COL_W-1:0]  col_r, s1_col_r;
  logic              s1_v_r;
  logic [AW-1:0]     w_base_r, a_base_r, b_base_r;
  logic [DIST_W-1:0] left_r, diag_r, mn_r, last_r;
  logic [7:0]        qprev_r, cand_prev_r, q_rd_r;
  logic [DIST_W-1:0] a_rd_r, b_rd_r;

  logic              out_valid_r;
  logic [23:0]       out_data_r;

  logic [COL_W-1:0]  n;
  logic              issue;
  logic              push_ok;
  logic              q_we;
  logic [PW-1:0]     prod;
  logic [COL_W-1:0]  colm1;
  logic [AW-1:0]     a_addr, b_addr, w_addr;

  logic [COL_W-1:0]  k;
  logic [DIST_W-1:0] up6, t6, v_build, v_rep, v;
  logic              cost, trans;
  logic [DIST_W:0]   c_up, c_left, c_diag, c_tr, m2, m3;

  assign n = ({1'b0, qlen_r} > 7'(MAX_QUERY)) ? COL_W'(MAX_QUERY) : COL_W'(qlen_r);
  assign issue   = cmd.walk && (col_r <= n);
  assign push_ok = (mode_t'(mode_r) == MODE_PUSH) && (rc_r < RC_W'(MAX_ROWS));
  assign q_we    = cmd.exec && (mode_t'(mode_r) == MODE_LOAD) &&
                   ({2'b00, qi_r} < 7'(MAX_QUERY));
  assign prod    = PW'(rc_r) * PW'(MAX_QUERY);

  assign colm1  = col_r - COL_W'(1);
  assign a_addr = a_base_r + AW'(colm1);
  assign b_addr = b_base_r + AW'(col_r - COL_W'(3));
  assign w_addr = w_base_r + AW'(s1_col_r - COL_W'(1));

  assign stat.push_ok   = push_ok;
  assign stat.walk_done = (col_r > n) && !s1_v_r;
  assign stat.out_free  = !out_valid_r || out_tready;

  // one column of the new row, or of the last stored row when no row is built
  always_comb begin
    k      = s1_col_r;
    up6    = (rc_r == RC_W'(1)) ? dsat(8'(k)) : a_rd_r;
    cost   = (ch_r != q_rd_r);
    c_up   = {1'b0, up6} + 7'd1;
    c_left = {1'b0, left_r} + 7'd1;
    c_diag = {1'b0, diag_r} + {6'd0, cost};
    m2     = min7(min7(c_up, c_left), c_diag);
    // entry two rows up and two columns left, edges of the table included
    if (rc_r == RC_W'(2)) begin
      t6 = 6'(k - COL_W'(2));
    end else if (k == COL_W'(2)) begin
      t6 = 6'(rc_r - RC_W'(2));
    end else begin
      t6 = b_rd_r;
    end
    c_tr  = {1'b0, t6} + 7'd1;
    trans = (rc_r >= RC_W'(2)) && (k >= COL_W'(2)) &&
            (ch_r == qprev_r) && (cand_prev_r == q_rd_r);
    m3    = (trans && (c_tr < m2)) ? c_tr : m2;
    v_build = (m3 > 7'(DIST_MAX)) ? DIST_MAX : m3[DIST_W-1:0];
    v_rep   = (rc_r == '0) ? dsat(8'(k)) : a_rd_r;
    v       = build_r ? v_build : v_rep;
  end

  // memories
  always_ff @(posedge clk) begin
    if (q_we) qmem[QA_W'(qi_r)] <= ch_r;
    if (cmd.exec && push_ok) begin
      cmem[CA_W'(rc_r)] <= ch_r;
      cand_prev_r       <= cmem[CA_W'(rc_r - RC_W'(1))];
    end
    if (s1_v_r && build_r) row_mem[w_addr] <= v;
    if (issue) begin
      q_rd_r <= qmem[QA_W'(colm1)];
      a_rd_r <= row_mem[a_addr];
      b_rd_r <= row_mem[b_addr];
    end
  end

  // captured word and walk payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_tuser[1:0];
      ch_r   <= in_tdata[7:0];
      qi_r   <= in_tdata[12:8];
      keep_r <= in_tdata[18:13];
    end
    if (cmd.exec) begin
      full_r <= (mode_t'(mode_r) == MODE_PUSH) && !push_ok;
    end
    if (cmd.exec && push_ok) begin
      w_base_r <= AW'(prod);
      a_base_r <= AW'(prod - PW'(MAX_QUERY));
      b_base_r <= AW'(prod - PW'(2 * MAX_QUERY));
      left_r   <= dsat(8'(rc_r) + 8'd1);
      mn_r     <= dsat(8'(rc_r) + 8'd1);
      last_r   <= dsat(8'(rc_r) + 8'd1);
      diag_r   <= dsat(8'(rc_r));
    end else if (cmd.rep_init) begin
      a_base_r <= AW'(prod - PW'(MAX_QUERY));
      mn_r     <= dsat(8'(rc_r));
      last_r   <= dsat(8'(rc_r));
    end else if (s1_v_r) begin
      mn_r    <= (v < mn_r) ? v : mn_r;
      if (k == n) last_r <= v;
      left_r  <= v;
      diag_r  <= up6;
      qprev_r <= q_rd_r;
    end
    s1_col_r <= col_r;
    if (cmd.emit) begin
      out_data_r <= {3'b000, full_r, 6'(rc_r), (mn_r <= maxd_r), (last_r <= maxd_r),
                     mn_r, last_r};
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlen_r      <= 6'd0;
      maxd_r      <= 6'd1;
      rc_r        <= '0;
      build_r     <= 1'b0;
      col_r       <= '0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wen) begin
        unique case (cfg_index)
          CFG_QUERY_LENGTH: qlen_r <= cfg_wdata;
          CFG_MAX_DISTANCE: maxd_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.exec) begin
        build_r <= push_ok;
        col_r   <= COL_W'(1);
        unique case (mode_t'(mode_r))
          MODE_PUSH:  if (push_ok) rc_r <= rc_r + RC_W'(1);
          MODE_TRUNC: if (8'(keep_r) < 8'(rc_r)) rc_r <= RC_W'(keep_r);
          MODE_LOAD, MODE_NONE: ;
          default: ;
        endcase
      end else if (cmd.rep_init) begin
        build_r <= 1'b0;
        col_r   <= COL_W'(1);
      end else if (issue) begin
        col_r <= col_r + COL_W'(1);
      end
      s1_v_r <= issue;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

>>> rtl/osa_edit_distance_rows.sv
// top level of the optimal string alignment row engine
// Usage:
//   configuration: cfg_wen/cfg_index/cfg_wdata, index 0 query length, index 1 max distance;
//   write only while the engine is idle.
//   input words: in_tuser selects load query char, push candidate char, truncate rows
//   or no-op. Every word gives one result word on out_*.
//   sequencing: a push that finds room goes from decode straight to the column walk,
//   other words pass through the replay init state first; n is the query length in use
//   (at most MAX_QUERY). The walk steps through the row memory, one query column a cycle.
//   One word is in work at a time, so the next word is taken only once the last one
//   has handed its result to the output register.
//   the result sits in an output register; the next word is taken while it waits,
//   and the engine holds its following result until out_tready frees the register.
//   reset: stack empty, query length 0, max distance 1, no result pending.
//   query, candidate and row memories are not cleared; software loads the query
//   and truncates to zero rows before walking.
`default_nettype none

module osa_edit_distance_rows
  import osaed_pkg::*;
#(
  parameter int MAX_QUERY = 32,
  parameter int MAX_ROWS  = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wen,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [5:0]  cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // char_value, query_index, keep_rows
  input  wire logic [7:0]  in_tuser,   // mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // last_distance, row_minimum, within_limit,
                                       // may_continue, rows_held, status
);

  osaed_cmd_t  cmd;
  osaed_stat_t stat;

  osaed_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  osaed_datapath #(
    .MAX_QUERY (MAX_QUERY),
    .MAX_ROWS  (MAX_ROWS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

>>> rtl/osaed_checker.sv
// port-level checks for the edit distance row engine, bound to the top level
`default_nettype none

module osaed_checker #(
  parameter int MAX_ROWS = 32
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

  // the row minimum covers the last column too
  a_min_le_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[11:6] <= out_tdata[5:0])
    else $error("row minimum above last distance");

  // a refused push only happens on a full stack
  a_full_rows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[20] |-> out_tdata[19:14] == 6'(MAX_ROWS))
    else $error("push refused with room on the stack");

endmodule

bind osa_edit_distance_rows osaed_checker #(.MAX_ROWS(MAX_ROWS)) u_osaed_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
